>>> rtl/escd_pkg.sv
// shared types, constants and calendar tables for the epoch-seconds to civil-date converter
package escd_pkg;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DAY,
      ST_HOUR,
      ST_MIN,
      ST_CYCLE,
      ST_YEAR,
      ST_MONTH
   } state_type;

   // working widths
   localparam int unsigned REM_W  = 33;   // biased seconds, always non-negative
   localparam int unsigned DAYS_W = 16;   // days since 1900-01-01
   localparam int unsigned CNT_W  = 4;    // quotient bit index

   // seconds from 1900-01-01 to 1970-01-01 with the every-fourth-year rule
   // (25568 days), so the biased count is never negative
   localparam logic [REM_W-1:0] SECS_BIAS = 33'd2209075200;

   // divisors of the shared subtract unit
   localparam logic [REM_W-1:0] SECS_PER_DAY  = 33'd86400;
   localparam logic [REM_W-1:0] SECS_PER_HOUR = 33'd3600;
   localparam logic [REM_W-1:0] SECS_PER_MIN  = 33'd60;
   localparam logic [REM_W-1:0] DAYS_PER_QUAD = 33'd1461;
   localparam logic [REM_W-1:0] DAYS_LEAP     = 33'd366;
   localparam logic [REM_W-1:0] DAYS_COMMON   = 33'd365;

   // top quotient bit index of each division
   localparam logic [CNT_W-1:0] DAY_TOP_BIT   = 4'd15;
   localparam logic [CNT_W-1:0] HOUR_TOP_BIT  = 4'd4;
   localparam logic [CNT_W-1:0] MIN_TOP_BIT   = 4'd5;
   localparam logic [CNT_W-1:0] CYCLE_TOP_BIT = 4'd5;

   localparam logic [3:0] LAST_MONTH = 4'd11;

   // first day of month m within the year, one extra day after february in a leap year
   function automatic logic [8:0] month_first(input logic [3:0] m, input logic leap);
      logic [8:0] base;
      begin
         case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd334;
         endcase
         month_first = base + {8'd0, (leap && (m > 4'd1))};
      end
   endfunction

   // day count modulo 7 by folding octal digits (8 is 1 mod 7)
   function automatic logic [2:0] mod7(input logic [DAYS_W-1:0] d);
      logic [5:0] s1;
      logic [3:0] s2;
      begin
         s1 = 6'(d[2:0]) + 6'(d[5:3]) + 6'(d[8:6]) + 6'(d[11:9])
            + 6'(d[14:12]) + 6'(d[15]);
         s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
         mod7 = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
      end
   endfunction

endpackage

>>> rtl/epoch_seconds_to_civil_date.sv
// epoch seconds to broken-down utc date, one shared subtract unit under a small sequencer
//
// usage
//  - request channel: drive req_seconds_since_epoch (signed seconds since
//    1970-01-01 00:00:00 utc) and raise start; the request is taken at a rising
//    edge where start is high and busy is low
//  - result channel: rsp_valid is high for exactly one cycle while the rsp_
//    ports hold the date; the receiver cannot stall, so it must take it then
//  - datapath: the single 33-bit compare-subtract unit does one quotient bit
//    or one search step per cycle, in this order: the day count (16 quotient
//    bits), the hour (5), the minute (6), the four-year cycle (6), then a
//    search for the year within the cycle and a search for the month; the
//    result is registered when the month search ends
//  - throughput: one request at a time; busy stays high until the result
//    cycle, and a new request may be taken in the cycle rsp_valid is shown
//  - reset (synchronous, active high) returns the sequencer to idle and drops
//    rsp_valid; the other registers are not reset
//  - the seconds are biased to 1900-01-01 so all division is unsigned and the
//    day is floored for negative inputs
module epoch_seconds_to_civil_date (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_seconds_since_epoch,
   output logic               rsp_valid,
   output logic [7:0]         rsp_years_since_1900,
   output logic [3:0]         rsp_month_index,
   output logic [4:0]         rsp_day_of_month,
   output logic [8:0]         rsp_day_of_year,
   output logic [2:0]         rsp_weekday,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second
);

   // sequencer and shared datapath registers
   escd_pkg::state_type state_ff, state_in;
   logic [escd_pkg::REM_W-1:0]  rem_ff, rem_in;     // running remainder
   logic [escd_pkg::DAYS_W-1:0] quo_ff, quo_in;     // quotient shift register
   logic [escd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;     // quotient bit index
   logic [escd_pkg::DAYS_W-1:0] days_ff, days_in;   // days since 1900-01-01
   logic [4:0]                  hour_ff, hour_in;
   logic [5:0]                  minute_ff, minute_in;
   logic [5:0]                  second_ff, second_in;
   logic [5:0]                  cyc_ff, cyc_in;     // four-year cycles since 1900
   logic [1:0]                  yoff_ff, yoff_in;   // year within the cycle
   logic [3:0]                  mon_ff, mon_in;

   // result registers
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_year_ff, rsp_year_in;
   logic [3:0] rsp_mon_ff, rsp_mon_in;
   logic [4:0] rsp_mday_ff, rsp_mday_in;
   logic [8:0] rsp_yday_ff, rsp_yday_in;
   logic [2:0] rsp_wday_ff, rsp_wday_in;
   logic [4:0] rsp_hour_ff, rsp_hour_in;
   logic [5:0] rsp_min_ff, rsp_min_in;
   logic [5:0] rsp_sec_ff, rsp_sec_in;

   // shared compare-subtract unit
   logic [escd_pkg::REM_W-1:0] op_base;
   logic [escd_pkg::REM_W-1:0] operand;
   logic [escd_pkg::REM_W:0]   diff;
   logic                       ge;
   logic                       leap;
   logic [8:0]                 yday;
   logic [8:0]                 mday_full;

   assign leap = (yoff_ff == 2'd0);   // 1900 + 4k is a leap year under the plain rule
   assign yday = rem_ff[8:0];

   // operand select: divisor shifted to the current quotient bit, or a year or month bound
   always_comb begin
      case (state_ff)
         escd_pkg::ST_DAY:   op_base = escd_pkg::SECS_PER_DAY;
         escd_pkg::ST_HOUR:  op_base = escd_pkg::SECS_PER_HOUR;
         escd_pkg::ST_MIN:   op_base = escd_pkg::SECS_PER_MIN;
         escd_pkg::ST_CYCLE: op_base = escd_pkg::DAYS_PER_QUAD;
         default:            op_base = '0;
      endcase
      case (state_ff)
         escd_pkg::ST_YEAR:
            operand = leap ? escd_pkg::DAYS_LEAP : escd_pkg::DAYS_COMMON;
         escd_pkg::ST_MONTH:
            operand = {24'd0, escd_pkg::month_first(mon_ff + 4'd1, leap)};
         default:
            operand = op_base << cnt_ff;
      endcase
   end

   assign diff      = {1'b0, rem_ff} - {1'b0, operand};
   assign ge        = ~diff[escd_pkg::REM_W];
   assign mday_full = yday - escd_pkg::month_first(mon_ff, leap) + 9'd1;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      days_in      = days_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      cyc_in       = cyc_ff;
      yoff_in      = yoff_ff;
      mon_in       = mon_ff;
      rsp_valid_in = 1'b0;
      rsp_year_in  = rsp_year_ff;
      rsp_mon_in   = rsp_mon_ff;
      rsp_mday_in  = rsp_mday_ff;
      rsp_yday_in  = rsp_yday_ff;
      rsp_wday_in  = rsp_wday_ff;
      rsp_hour_in  = rsp_hour_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_sec_in   = rsp_sec_ff;

      case (state_ff)
         escd_pkg::ST_IDLE: begin
            if (start) begin
               // sign-extend and bias so the count is non-negative
               rem_in   = {req_seconds_since_epoch[31], req_seconds_since_epoch}
                        + escd_pkg::SECS_BIAS;
               quo_in   = '0;
               cnt_in   = escd_pkg::DAY_TOP_BIT;
               state_in = escd_pkg::ST_DAY;
            end
         end

         escd_pkg::ST_DAY, escd_pkg::ST_HOUR, escd_pkg::ST_MIN, escd_pkg::ST_CYCLE: begin
            // one restoring division step
            if (ge) begin
               rem_in = diff[escd_pkg::REM_W-1:0];
            end
            quo_in = {quo_ff[escd_pkg::DAYS_W-2:0], ge};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               quo_in = '0;
               case (state_ff)
                  escd_pkg::ST_DAY: begin
                     days_in  = {quo_ff[escd_pkg::DAYS_W-2:0], ge};
                     cnt_in   = escd_pkg::HOUR_TOP_BIT;
                     state_in = escd_pkg::ST_HOUR;
                  end
                  escd_pkg::ST_HOUR: begin
                     hour_in  = {quo_ff[3:0], ge};
                     cnt_in   = escd_pkg::MIN_TOP_BIT;
                     state_in = escd_pkg::ST_MIN;
                  end
                  escd_pkg::ST_MIN: begin
                     minute_in = {quo_ff[4:0], ge};
                     second_in = ge ? diff[5:0] : rem_ff[5:0];
                     rem_in    = {17'd0, days_ff};
                     cnt_in    = escd_pkg::CYCLE_TOP_BIT;
                     state_in  = escd_pkg::ST_CYCLE;
                  end
                  default: begin
                     cyc_in   = {quo_ff[4:0], ge};
                     yoff_in  = 2'd0;
                     state_in = escd_pkg::ST_YEAR;
                  end
               endcase
            end
         end

         escd_pkg::ST_YEAR: begin
            // peel whole years off the day within the four-year cycle
            if (ge) begin
               rem_in  = diff[escd_pkg::REM_W-1:0];
               yoff_in = yoff_ff + 2'd1;
            end else begin
               mon_in   = yday[8:5];   // never past the true month
               state_in = escd_pkg::ST_MONTH;
            end
         end

         escd_pkg::ST_MONTH: begin
            if ((mon_ff < escd_pkg::LAST_MONTH) && ge) begin
               mon_in = mon_ff + 4'd1;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_year_in  = {cyc_ff, yoff_ff};
               rsp_mon_in   = mon_ff;
               rsp_mday_in  = mday_full[4:0];
               rsp_yday_in  = yday;
               rsp_wday_in  = escd_pkg::mod7(days_ff);  // 1900-01-01 counts as day 0 mod 7
               rsp_hour_in  = hour_ff;
               rsp_min_in   = minute_ff;
               rsp_sec_in   = second_ff;
               state_in     = escd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = escd_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= escd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      days_ff     <= days_in;
      hour_ff     <= hour_in;
      minute_ff   <= minute_in;
      second_ff   <= second_in;
      cyc_ff      <= cyc_in;
      yoff_ff     <= yoff_in;
      mon_ff      <= mon_in;
      rsp_year_ff <= rsp_year_in;
      rsp_mon_ff  <= rsp_mon_in;
      rsp_mday_ff <= rsp_mday_in;
      rsp_yday_ff <= rsp_yday_in;
      rsp_wday_ff <= rsp_wday_in;
      rsp_hour_ff <= rsp_hour_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_sec_ff  <= rsp_sec_in;
   end

   assign busy                 = (state_ff != escd_pkg::ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_years_since_1900 = rsp_year_ff;
   assign rsp_month_index      = rsp_mon_ff;
   assign rsp_day_of_month     = rsp_mday_ff;
   assign rsp_day_of_year      = rsp_yday_ff;
   assign rsp_weekday          = rsp_wday_ff;
   assign rsp_hour             = rsp_hour_ff;
   assign rsp_minute           = rsp_min_ff;
   assign rsp_second           = rsp_sec_ff;

   // a result only follows the end of the month search
   a_rsp_after_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == escd_pkg::ST_MONTH))
      else $error("result strobe without a finished month search");

   // an accepted request starts the day division
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == escd_pkg::ST_DAY))
      else $error("accepted request did not start the day division");

   // the time of day fields come out in range
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("time of day out of range");

   // the date fields come out in range
   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_index <= 4'd11 && rsp_day_of_month != 5'd0
                     && rsp_weekday <= 3'd6 && rsp_day_of_year <= 9'd365))
      else $error("date field out of range");

   // the year search never passes the last year of a four-year cycle
   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == escd_pkg::ST_YEAR && yoff_ff == 2'd3) |-> !ge)
      else $error("year search ran past the four-year cycle");

endmodule

>>> tb/sv/testbench.sv
// self-checking testbench for the epoch-seconds to civil-date converter
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // one broken-down utc date, field widths as on the result ports
   typedef struct packed {
      logic [7:0] years_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
      logic [8:0] day_of_year;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } civil_date_type;

   // one row of the directed table; typed rows carry a hand-written date
   typedef struct {
      logic [31:0]    secs;
      bit             typed;
      civil_date_type want;
   } stim_row_type;

   localparam longint SECS_IN_DAY    = 86400;
   localparam longint SECS_MIN       = -64'sd2147483648;
   localparam longint SECS_MAX       = 64'sd2147483647;
   localparam int     RANDOM_COUNT   = 1200;
   localparam int     CALM_TAIL      = 150;    // last requests sent back to back
   localparam int     WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
   localparam int     DRAIN_CYCLES   = 60;     // a bit more than the worst latency

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_seconds_since_epoch;
   logic               rsp_valid;
   logic [7:0]         rsp_years_since_1900;
   logic [3:0]         rsp_month_index;
   logic [4:0]         rsp_day_of_month;
   logic [8:0]         rsp_day_of_year;
   logic [2:0]         rsp_weekday;
   logic [4:0]         rsp_hour;
   logic [5:0]         rsp_minute;
   logic [5:0]         rsp_second;

   // dates still owed by the block, oldest first, with the seconds that asked for them
   civil_date_type pending_dates[$];
   logic [31:0]    pending_secs[$];
   int             fail_count   = 0;
   int             quiet_cycles = 0;

   // cumulative days before each month in a common year
   int month_start_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   epoch_seconds_to_civil_date u_top (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_seconds_since_epoch (req_seconds_since_epoch),
      .rsp_valid               (rsp_valid),
      .rsp_years_since_1900    (rsp_years_since_1900),
      .rsp_month_index         (rsp_month_index),
      .rsp_day_of_month        (rsp_day_of_month),
      .rsp_day_of_year         (rsp_day_of_year),
      .rsp_weekday             (rsp_weekday),
      .rsp_hour                (rsp_hour),
      .rsp_minute              (rsp_minute),
      .rsp_second              (rsp_second)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // epoch day of january 1 of calendar year yr, every fourth year a leap year
   function automatic longint jan1_day(input longint yr);
      longint n;
      longint q;
      n = yr - 1969;
      q = n / 4;
      if (n % 4 < 0) q = q - 1;   // floor for years before 1969
      return 365 * (yr - 1970) + q;
   endfunction

   // day within the year where month mon begins, leap day pushes march onward
   function automatic longint month_first_day(input int mon, input bit leap);
      return longint'(month_start_days[mon] + ((leap && mon > 1) ? 1 : 0));
   endfunction

   // expected date for a request
   function automatic civil_date_type civil_from_seconds(input logic [31:0] secs);
      civil_date_type d;
      longint         s;
      longint         day_num;
      longint         tod;
      longint         yr;
      longint         yd;
      int             mon;
      bit             leap;
      s       = longint'($signed(secs));
      day_num = s / SECS_IN_DAY;
      tod     = s % SECS_IN_DAY;
      // negative counts land in the previous day with a positive time of day
      if (tod < 0) begin
         tod     = tod + SECS_IN_DAY;
         day_num = day_num - 1;
      end
      // rough year, then settle it from both sides
      yr = 1970 + day_num / 365;
      while (jan1_day(yr) > day_num) yr = yr - 1;
      while (jan1_day(yr + 1) <= day_num) yr = yr + 1;
      yd   = day_num - jan1_day(yr);
      leap = (yr % 4 == 0);
      // search down from december
      mon = 11;
      while (yd < month_first_day(mon, leap)) mon = mon - 1;
      d.years_since_1900 = 8'(yr - 1900);
      d.month_index      = 4'(mon);
      d.day_of_month     = 5'(yd - month_first_day(mon, leap) + 1);
      d.day_of_year      = 9'(yd);
      // day zero was a thursday
      d.weekday          = 3'(((day_num % 7) + 11) % 7);
      d.hour             = 5'(tod / 3600);
      d.minute           = 6'((tod % 3600) / 60);
      d.second           = 6'(tod % 60);
      return d;
   endfunction

   function automatic civil_date_type date_of(input int y, input int m, input int dm,
                                              input int yd, input int wd, input int h,
                                              input int mi, input int s);
      civil_date_type d;
      d.years_since_1900 = 8'(y);
      d.month_index      = 4'(m);
      d.day_of_month     = 5'(dm);
      d.day_of_year      = 9'(yd);
      d.weekday          = 3'(wd);
      d.hour             = 5'(h);
      d.minute           = 6'(mi);
      d.second           = 6'(s);
      return d;
   endfunction

   // random request: raw patterns for two fifths, the rest aimed at day, year and month edges and the range ends
   function automatic logic [31:0] random_seconds();
      longint t;
      longint yr;
      int     kind;
      kind = $urandom_range(0, 99);
      if (kind < 40) return $urandom();
      if (kind < 60) begin
         // midnight of a random day, give or take a second
         t = (longint'($urandom_range(0, 49710)) - 24856) * SECS_IN_DAY
           + longint'($urandom_range(0, 2)) - 1;
      end else if (kind < 78) begin
         // new year, give or take two seconds
         yr = longint'($urandom_range(1902, 2038));
         t  = jan1_day(yr) * SECS_IN_DAY + longint'($urandom_range(0, 4)) - 2;
      end else if (kind < 94) begin
         // first of a month; one second early gives month ends, leap days and december 31
         yr = longint'($urandom_range(1902, 2037));
         t  = (jan1_day(yr) + month_first_day($urandom_range(0, 11), yr % 4 == 0))
              * SECS_IN_DAY + longint'($urandom_range(0, 2)) - 1;
      end else if (kind < 97) begin
         t = SECS_MIN + longint'($urandom_range(0, 200000));
      end else begin
         t = SECS_MAX - longint'($urandom_range(0, 200000));
      end
      if (t < SECS_MIN || t > SECS_MAX) return $urandom();
      return 32'(t);
   endfunction

   // present one request and hold it until the block takes it; returns at a falling edge
   task automatic send_request(input logic [31:0] secs, input civil_date_type want);
      req_seconds_since_epoch <= secs;
      start                   <= 1'b1;
      do @(posedge clock); while (busy);
      pending_dates.push_back(want);
      pending_secs.push_back(secs);
      @(negedge clock);
   endtask

   // random idle burst, sometimes only after the block has gone idle
   task automatic idle_burst();
      int gap;
      if ($urandom_range(0, 9) < 3) begin
         gap = $urandom_range(1, 15);
         start <= 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            do @(posedge clock); while (busy);
            @(negedge clock);
         end
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] secs,
                              input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s for seconds %0d: expected %0d, actual %0d",
                  $time, field, $signed(secs), want, got);
         fail_count++;
      end
   endtask

   // result checker and watchdog
   always @(posedge clock) begin
      civil_date_type want;
      logic [31:0]    secs;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_dates.size() == 0) begin
               $display("%0t: result with no request outstanding, expected none, actual %0d",
                        $time, rsp_years_since_1900);
               fail_count++;
            end else begin
               want = pending_dates.pop_front();
               secs = pending_secs.pop_front();
               check_field("years_since_1900", secs, 32'(want.years_since_1900),
                           32'(rsp_years_since_1900));
               check_field("month_index", secs, 32'(want.month_index),
                           32'(rsp_month_index));
               check_field("day_of_month", secs, 32'(want.day_of_month),
                           32'(rsp_day_of_month));
               check_field("day_of_year", secs, 32'(want.day_of_year),
                           32'(rsp_day_of_year));
               check_field("weekday", secs, 32'(want.weekday), 32'(rsp_weekday));
               check_field("hour", secs, 32'(want.hour), 32'(rsp_hour));
               check_field("minute", secs, 32'(want.minute), 32'(rsp_minute));
               check_field("second", secs, 32'(want.second), 32'(rsp_second));
            end
         end
         // any handshake on either side counts as progress
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type   rows[$];
      civil_date_type want;
      logic [31:0]    secs;
      reset                   = 1'b1;
      start                   = 1'b0;
      req_seconds_since_epoch = '0;

      // epoch, last second before it, and both range ends typed in by hand
      rows.push_back('{32'h00000000, 1'b1, date_of(70, 0, 1, 0, 4, 0, 0, 0)});
      rows.push_back('{32'hFFFFFFFF, 1'b1, date_of(69, 11, 31, 364, 3, 23, 59, 59)});
      rows.push_back('{32'h80000000, 1'b1, date_of(1, 11, 13, 346, 5, 20, 45, 52)});
      rows.push_back('{32'h7FFFFFFF, 1'b1, date_of(138, 0, 19, 18, 2, 3, 14, 7)});
      // day edges on both sides of the epoch, and neighbours of the epoch and of both range ends
      rows.push_back('{32'd86399, 1'b0, '0});
      rows.push_back('{32'd86400, 1'b0, '0});
      rows.push_back('{-32'sd86400, 1'b0, '0});
      rows.push_back('{-32'sd86401, 1'b0, '0});
      rows.push_back('{32'd1, 1'b0, '0});
      rows.push_back('{32'h80000001, 1'b0, '0});
      rows.push_back('{32'h7FFFFFFE, 1'b0, '0});
      // leap days and the day after
      rows.push_back('{32'd68169600, 1'b0, '0});
      rows.push_back('{32'd951782400, 1'b0, '0});
      rows.push_back('{32'd951868800, 1'b0, '0});
      rows.push_back('{-32'sd2077747200, 1'b0, '0});
      // december 31 in leap and common years
      rows.push_back('{32'd94694399, 1'b0, '0});
      rows.push_back('{32'd978307199, 1'b0, '0});
      rows.push_back('{32'd946684799, 1'b0, '0});
      rows.push_back('{-32'sd2145916801, 1'b0, '0});
      // alternating and half-word bit patterns
      rows.push_back('{32'h55555555, 1'b0, '0});
      rows.push_back('{32'hAAAAAAAA, 1'b0, '0});
      rows.push_back('{32'h0000FFFF, 1'b0, '0});
      rows.push_back('{32'hFFFF0000, 1'b0, '0});

      // reset once, releasing it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (rows[i]) begin
         want = rows[i].typed ? rows[i].want : civil_from_seconds(rows[i].secs);
         idle_burst();
         send_request(rows[i].secs, want);
      end

      // random part, back to back at the end
      for (int k = 0; k < RANDOM_COUNT; k++) begin
         secs = random_seconds();
         if (k < RANDOM_COUNT - CALM_TAIL) idle_burst();
         send_request(secs, civil_from_seconds(secs));
      end
      start <= 1'b0;

      // drain, then give a stray result time to show up
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
